/* src/ed_pkg.sv */
`default_nettype none

package ed_pkg;

  // kind of input item, carried on the slave tuser
  typedef enum logic [1:0] {
    ACT_APPEND_A = 2'd0,
    ACT_TAKE_B   = 2'd1,
    ACT_EMIT     = 2'd2,
    ACT_NONE     = 2'd3
  } action_t;

  localparam int SYM_W   = 8;
  localparam int FIELD_W = 7;  // width of each result count
  localparam int OUT_W   = 24; // three counts and the flag, padded to bytes

endpackage

`default_nettype wire

/* src/ed_ram.sv */
`default_nettype none

// simple dual-port RAM, one write and one registered read per cycle
module ed_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

/* src/edit_distance_dp_top.sv */
`default_nettype none

// Levenshtein distance engine. Items on the slave stream carry a kind in tuser
// (append a byte of A, take a byte of B, emit and clear) and a byte in tdata.
// A is stored in a byte RAM and one DP row over A is kept in a second RAM; a B
// byte walks that row one cell per cycle through the row RAM's single read and
// write port. An emit waits in S_EMIT for room on the master side. The row
// needs no clearing after reset or emit: until the first B byte it reads as
// its boundary values, and that byte rewrites every entry up to len(A).
// Bytes beyond MAX_LEN are dropped and set too_long; A bytes after a B byte
// are dropped silently.
module edit_distance_dp_top #(
  parameter int MAX_LEN = 64
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       s_axis_tvalid,
  output logic                            s_axis_tready,
  input  wire logic [ed_pkg::SYM_W-1:0]   s_axis_tdata,  // [7:0] symbol
  input  wire logic [1:0]                 s_axis_tuser,  // [1:0] action
  output logic                            m_axis_tvalid,
  input  wire logic                       m_axis_tready,
  // [6:0] distance, [13:7] length_of_a, [20:14] length_of_b, [21] too_long
  output logic [ed_pkg::OUT_W-1:0]        m_axis_tdata
);

  localparam int CW  = $clog2(MAX_LEN + 1);
  localparam int TAW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
  localparam int FW  = ed_pkg::FIELD_W;

  typedef enum logic [1:0] {S_IDLE, S_ROW, S_EMIT} state_t;

  state_t                   state;
  logic [CW-1:0]            count_a;
  logic [CW-1:0]            count_b;
  logic                     overflow;
  logic [CW-1:0]            col;
  logic [CW-1:0]            diag;
  logic [CW-1:0]            left;
  logic                     virgin;
  logic [ed_pkg::SYM_W-1:0] sym;

  ed_pkg::action_t          action;
  logic                     accept;
  logic                     last_col;
  logic                     out_free;

  logic                     text_we;
  logic [TAW-1:0]           text_raddr;
  logic [ed_pkg::SYM_W-1:0] text_rdata;
  logic                     dp_we;
  logic [CW-1:0]            dp_raddr;
  logic [CW-1:0]            dp_rdata;

  logic [CW-1:0]            up;
  logic [CW-1:0]            min_dl;
  logic [CW-1:0]            min_all;
  logic [CW-1:0]            row_val;
  logic [CW-1:0]            distance;

  assign action        = ed_pkg::action_t'(s_axis_tuser);
  assign s_axis_tready = (state == S_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign last_col      = (col == count_a);
  assign out_free      = !m_axis_tvalid || m_axis_tready;

  assign text_we = accept && (action == ed_pkg::ACT_APPEND_A) && (count_b == '0) &&
                   (count_a < CW'(MAX_LEN));
  // cell col+1 compares against A byte col
  assign text_raddr = (col < CW'(MAX_LEN)) ? col[TAW-1:0] : '0;

  always_comb begin
    unique case (state)
      S_IDLE:  dp_raddr = (action == ed_pkg::ACT_EMIT) ? count_a : '0;
      S_ROW:   dp_raddr = last_col ? col : col + CW'(1);
      S_EMIT:  dp_raddr = count_a;
      default: dp_raddr = '0;
    endcase
  end

  // before the first B byte has rewritten it, the row reads as its boundary values
  assign up      = virgin ? col : dp_rdata;
  assign min_dl  = (diag < left) ? diag : left;
  assign min_all = (min_dl < up) ? min_dl : up;

  always_comb begin
    if (col == '0) begin
      row_val = count_b + CW'(1);
    end else if (text_rdata == sym) begin
      row_val = diag;
    end else begin
      row_val = min_all + CW'(1);
    end
  end

  assign dp_we    = (state == S_ROW);
  assign distance = (count_b == '0) ? count_a : dp_rdata;

  ed_ram #(
    .WIDTH (ed_pkg::SYM_W),
    .DEPTH (MAX_LEN),
    .AW    (TAW)
  ) u_text (
    .clk   (clk),
    .we    (text_we),
    .waddr (count_a[TAW-1:0]),
    .wdata (s_axis_tdata),
    .raddr (text_raddr),
    .rdata (text_rdata)
  );

  ed_ram #(
    .WIDTH (CW),
    .DEPTH (MAX_LEN + 1),
    .AW    (CW)
  ) u_row (
    .clk   (clk),
    .we    (dp_we),
    .waddr (col),
    .wdata (row_val),
    .raddr (dp_raddr),
    .rdata (dp_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      count_a       <= '0;
      count_b       <= '0;
      overflow      <= 1'b0;
      virgin        <= 1'b1;
      m_axis_tvalid <= 1'b0;
    end else begin
      // S_EMIT reloads the output register itself
      if (m_axis_tvalid && m_axis_tready && (state != S_EMIT)) begin
        m_axis_tvalid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            sym <= s_axis_tdata;
            unique case (action)
              ed_pkg::ACT_APPEND_A: begin
                if (count_b == '0) begin
                  if (count_a < CW'(MAX_LEN)) begin
                    count_a <= count_a + CW'(1);
                  end else begin
                    overflow <= 1'b1;
                  end
                end
              end
              ed_pkg::ACT_TAKE_B: begin
                if (count_b < CW'(MAX_LEN)) begin
                  col    <= '0;
                  virgin <= (count_b == '0);
                  state  <= S_ROW;
                end else begin
                  overflow <= 1'b1;
                end
              end
              ed_pkg::ACT_EMIT: state <= S_EMIT;
              ed_pkg::ACT_NONE: ;
              default: ;
            endcase
          end
        end
        S_ROW: begin
          diag <= up;
          left <= row_val;
          if (last_col) begin
            count_b <= count_b + CW'(1);
            state   <= S_IDLE;
          end else begin
            col <= col + CW'(1);
          end
        end
        S_EMIT: begin
          if (out_free) begin
            m_axis_tvalid <= 1'b1;
            m_axis_tdata  <= {2'b00, overflow, FW'(count_b), FW'(count_a), FW'(distance)};
            count_a       <= '0;
            count_b       <= '0;
            overflow      <= 1'b0;
            state         <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

/* sim/tb.sv */
`default_nettype none

module tb;

  localparam int MAX_LEN         = 64;
  localparam int ITEMS_PER_PHASE = 400;
  localparam int STALL_LIMIT     = 20000;
  localparam int HOLD_CYCLES     = 1500;

  logic                       clk = 1'b0;
  logic                       rst = 1'b1;
  logic                       s_axis_tvalid = 1'b0;
  logic                       s_axis_tready;
  logic [ed_pkg::SYM_W-1:0]   s_axis_tdata = '0;
  logic [1:0]                 s_axis_tuser = ed_pkg::ACT_NONE;
  logic                       m_axis_tvalid;
  logic                       m_axis_tready = 1'b0;
  logic [ed_pkg::OUT_W-1:0]   m_axis_tdata;

  int send_idle_pct = 26;
  int recv_idle_pct = 69;
  bit hold_req = 1'b0;

  always #10 clk = ~clk;

  edit_distance_dp_top #(.MAX_LEN(MAX_LEN)) dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  class distance_scoreboard;
    typedef struct packed {
      logic       too_long;
      logic [6:0] len_b;
      logic [6:0] len_a;
      logic [6:0] distance;
    } dist_result_t;

    logic [7:0]   text_a [MAX_LEN];
    int           row [MAX_LEN+1];
    int           len_a;
    int           len_b;
    bit           too_long;
    dist_result_t expected_q [$];
    int           errors;

    function new();
      errors = 0;
      clear_state();
    endfunction

    function void clear_state();
      foreach (text_a[j]) text_a[j] = '0;
      for (int j = 0; j <= MAX_LEN; j++) row[j] = j;
      len_a = 0;
      len_b = 0;
      too_long = 1'b0;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    task report(string what, int want, int got);
      $display("%0t mismatch %s: expected %0d got %0d", $realtime, what, want, got);
      errors++;
    endtask

    // advance the DP state by one accepted item
    function void note_item(ed_pkg::action_t act, logic [7:0] sym);
      int diag;
      int up;
      int best;
      dist_result_t r;
      case (act)
        ed_pkg::ACT_APPEND_A: begin
          // A bytes after B has started are dropped silently
          if (len_b == 0) begin
            if (len_a >= MAX_LEN) too_long = 1'b1;
            else begin
              text_a[len_a] = sym;
              len_a++;
            end
          end
        end
        ed_pkg::ACT_TAKE_B: begin
          if (len_b >= MAX_LEN) too_long = 1'b1;
          else begin
            diag = row[0];
            row[0] = len_b + 1;
            for (int j = 1; j <= len_a; j++) begin
              up = row[j];
              if (text_a[j-1] == sym) row[j] = diag;
              else begin
                best = diag;
                if (row[j-1] < best) best = row[j-1];
                if (up < best) best = up;
                row[j] = best + 1;
              end
              diag = up;
            end
            len_b++;
          end
        end
        ed_pkg::ACT_EMIT: begin
          r.distance = 7'(row[len_a]);
          r.len_a    = 7'(len_a);
          r.len_b    = 7'(len_b);
          r.too_long = too_long;
          expected_q.push_back(r);
          clear_state();
        end
        default: ;
      endcase
    endfunction

    task check_result(logic [ed_pkg::OUT_W-1:0] data);
      dist_result_t got;
      dist_result_t want;
      got = data[21:0];
      if (expected_q.size() == 0) begin
        report("unexpected result, distance", -1, got.distance);
        return;
      end
      want = expected_q.pop_front();
      if (got.distance !== want.distance) report("distance", want.distance, got.distance);
      if (got.len_a !== want.len_a) report("length_of_a", want.len_a, got.len_a);
      if (got.len_b !== want.len_b) report("length_of_b", want.len_b, got.len_b);
      if (got.too_long !== want.too_long) report("too_long", want.too_long, got.too_long);
    endtask
  endclass

  distance_scoreboard sb = new();

  // result monitor
  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata);
  end

  // receiver: random backpressure plus one long hold-off on request
  initial begin : receiver
    int hold_left;
    hold_left = 0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        m_axis_tready <= 1'b0;
        hold_left--;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // watchdog: cycles without any item moving on either side
  initial begin : watchdog
    int stall_cycles;
    stall_cycles = 0;
    while (stall_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
        stall_cycles = 0;
      else
        stall_cycles++;
    end
    $display("edit_distance_dp_top verification failed");
    $finish;
  end

  task automatic send_item(ed_pkg::action_t act, logic [7:0] sym);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= sym;
    s_axis_tuser  <= act;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    sb.note_item(act, sym);
    @(negedge clk);
  endtask

  function automatic int pick_length();
    int r;
    r = int'($urandom_range(99));
    if (r < 70) return int'($urandom_range(8));
    if (r < 92) return int'($urandom_range(40, 9));
    return int'($urandom_range(MAX_LEN + 4, MAX_LEN - 4));
  endfunction

  // one string pair: appends, B bytes, usually an emit, with a little noise mixed in; or pure noise
  task automatic run_sequence(inout int counted);
    logic [7:0] alphabet [4];
    bit         narrow;
    int         a_len;
    int         b_len;
    logic [7:0] sym;
    if ($urandom_range(99) < 10) begin
      // pure noise, any kind including the unused one
      repeat ($urandom_range(6, 1))
        send_item(ed_pkg::action_t'($urandom_range(3)), 8'($urandom_range(255)));
      return;
    end
    narrow = ($urandom_range(99) < 60);
    foreach (alphabet[k]) alphabet[k] = 8'($urandom_range(255));
    a_len = pick_length();
    b_len = pick_length();
    repeat (a_len) begin
      sym = narrow ? alphabet[$urandom_range(3)] : 8'($urandom_range(255));
      if ($urandom_range(99) < 5) send_item(ed_pkg::ACT_NONE, 8'($urandom_range(255)));
      send_item(ed_pkg::ACT_APPEND_A, sym);
      counted++;
    end
    repeat (b_len) begin
      sym = narrow ? alphabet[$urandom_range(3)] : 8'($urandom_range(255));
      if ($urandom_range(99) < 5) send_item(ed_pkg::ACT_NONE, 8'($urandom_range(255)));
      if ($urandom_range(99) < 4) send_item(ed_pkg::ACT_APPEND_A, 8'($urandom_range(255)));
      send_item(ed_pkg::ACT_TAKE_B, sym);
      counted++;
    end
    if ($urandom_range(99) < 92) begin
      send_item(ed_pkg::ACT_EMIT, 8'($urandom_range(255)));
      counted++;
    end
  endtask

  initial begin : stimulus
    int  phase_items;
    bit  held;
    bit  drained;
    held = 1'b0;
    drained = 1'b0;
    repeat (9) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed: empty emit, byte extremes, A after B, unused kind,
    // empty A or empty B, exact match
    send_item(ed_pkg::ACT_EMIT,     8'h00);
    send_item(ed_pkg::ACT_APPEND_A, 8'h00);
    send_item(ed_pkg::ACT_APPEND_A, 8'hFF);
    send_item(ed_pkg::ACT_APPEND_A, 8'hA5);
    send_item(ed_pkg::ACT_NONE,     8'h5A);
    send_item(ed_pkg::ACT_TAKE_B,   8'hFF);
    send_item(ed_pkg::ACT_APPEND_A, 8'h3C);
    send_item(ed_pkg::ACT_TAKE_B,   8'h00);
    send_item(ed_pkg::ACT_TAKE_B,   8'hA5);
    send_item(ed_pkg::ACT_EMIT,     8'hFF);
    send_item(ed_pkg::ACT_TAKE_B,   8'h11);
    send_item(ed_pkg::ACT_TAKE_B,   8'h22);
    send_item(ed_pkg::ACT_EMIT,     8'h00);
    send_item(ed_pkg::ACT_APPEND_A, 8'h7E);
    send_item(ed_pkg::ACT_APPEND_A, 8'h81);
    send_item(ed_pkg::ACT_EMIT,     8'h00);
    send_item(ed_pkg::ACT_APPEND_A, 8'h42);
    send_item(ed_pkg::ACT_TAKE_B,   8'h42);
    send_item(ed_pkg::ACT_EMIT,     8'h00);
    send_item(ed_pkg::ACT_NONE,     8'hFF);
    send_item(ed_pkg::ACT_EMIT,     8'h00);

    for (int p = 0; p < 3; p++) begin
      case (p)
        0: begin send_idle_pct = 26; recv_idle_pct = 69; end
        1: begin send_idle_pct = 69; recv_idle_pct = 26; end
        default: begin send_idle_pct = 0; recv_idle_pct = 0; end
      endcase
      phase_items = 0;
      while (phase_items < ITEMS_PER_PHASE) begin
        if (p == 0 && !held && phase_items > 150) begin
          hold_req = 1'b1;
          held = 1'b1;
        end
        if (p == 1 && !drained && phase_items > 150) begin
          s_axis_tvalid <= 1'b0;
          while (sb.pending() != 0) @(posedge clk);
          @(negedge clk);
          drained = 1'b1;
        end
        run_sequence(phase_items);
      end
    end

    s_axis_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (2 * MAX_LEN + 10) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0)
      $display("edit_distance_dp_top verification clean");
    else
      $display("edit_distance_dp_top verification failed");
    $finish;
  end

endmodule

`default_nettype wire
